FILE: hw/rtl/vep_pkg.sv
// Shared types, constants and register indexes for the volume exclusion block.
// No dependencies.
package vep_pkg;

  localparam int unsigned MaxNeighbours = 256;
  localparam int unsigned CntW = 9;

  localparam logic [23:0] OneQ23 = 24'd8388608;
  localparam logic [24:0] HalfQ23 = 25'd4194304;

  typedef enum logic [1:0] {
    CFG_SMOOTH = 2'd0,
    CFG_COEF_A = 2'd1,
    CFG_COEF_B = 2'd2
  } cfg_idx_t;

  // Atom class as decided by the front end
  typedef enum logic [1:0] {
    CLS_FAR = 2'd0,
    CLS_OVERLAP = 2'd1,
    CLS_BAND = 2'd2
  } cls_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    cls_t cls;
    logic [49:0] d2;
    logic [15:0] radius;
    logic [15:0] id;
    logic last;
  } job_t;

  // Back end state machine
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQRT,
    BK_E2,
    BK_BT,
    BK_ET,
    BK_PROD,
    BK_OUT
  } bk_state_t;

endpackage

FILE: hw/rtl/volume_exclusion_product.sv
// Top level of the smoothed volume exclusion block: ports, config registers,
// front end, queue and back end. Uses vep_pkg, vep_front, vep_queue, vep_back.
//
// In the front end each atom takes three squared-distance terms on one
// multiplier, then the band compares. Banded atoms pass in the back end through
// an accept cycle, 25 square-root bit steps, three multiply stages, a clamp
// stage and the output cycle; atoms far away or overlapping go from the accept
// cycle straight to the output cycle. Output stalls add to the back-end time. The
// sequential back end with its bit-serial square root sets the sustained rate; a
// two-entry queue lets the front end classify the next atom meanwhile. One result
// per atom, in order.
module volume_exclusion_product #(
  parameter int unsigned MAX_NEIGHBOURS = vep_pkg::MaxNeighbours
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // point_x, point_y, point_z, atom_x, atom_y, atom_z, atom_radius, atom_id
  input  logic [175:0] in_tdata,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // contributes, contributor_id, overlapped, exclusion_value, contributor_count
  output logic [55:0] out_tdata,
  output logic out_tlast,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import vep_pkg::*;

  logic [15:0] smooth_r;
  logic [23:0] coef_a_r;
  logic [31:0] coef_b_r;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fjob, bjob;
  logic contributes, overlapped;
  logic [15:0] cid;
  logic [23:0] xval;
  logic [8:0] ccnt;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= 16'd1229;
      coef_a_r <= 24'd163840;
      coef_b_r <= 32'd606815;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SMOOTH: smooth_r <= cfg_data[15:0];
        CFG_COEF_A: coef_a_r <= cfg_data[23:0];
        CFG_COEF_B: coef_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vep_front u_front (
    .clk, .rst_n, .smooth(smooth_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .px(in_tdata[23:0]), .py(in_tdata[47:24]), .pz(in_tdata[71:48]),
    .ax(in_tdata[95:72]), .ay(in_tdata[119:96]), .az(in_tdata[143:120]),
    .radius(in_tdata[159:144]), .id(in_tdata[175:160]), .last(in_tlast),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fjob)
  );

  vep_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fjob),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bjob)
  );

  vep_back #(.MAX_NEIGHBOURS(MAX_NEIGHBOURS)) u_back (
    .clk, .rst_n, .coef_a(coef_a_r), .coef_b(coef_b_r),
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bjob),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .contributes, .contributor_id(cid), .overlapped, .run_done(out_tlast),
    .exclusion_value(xval), .contributor_count(ccnt)
  );

  assign out_tdata = {5'b0, ccnt, xval, overlapped, cid, contributes};

  // A product of zero follows every overlap
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && overlapped |-> xval == '0 && ccnt == '0 && !contributes)
    else $error("overlap result with nonzero product");
  // Product never exceeds one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> xval <= OneQ23)
    else $error("product above one");
  // Contributing atoms always have a nonzero count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && contributes |-> ccnt != '0)
    else $error("contributor with zero count");
endmodule

FILE: hw/rtl/vep_front.sv
// Front end: accepts atoms, forms squared distance, classifies far/overlap/band.
// Uses vep_pkg. Multi-cycle: one squared term per cycle, then band compares.
module vep_front (
  input  logic clk,
  input  logic rst_n,
  input  logic [15:0] smooth,
  input  logic in_valid,
  output logic in_ready,
  input  logic [23:0] px, py, pz, ax, ay, az,
  input  logic [15:0] radius,
  input  logic [15:0] id,
  input  logic last,
  output logic job_valid,
  input  logic job_ready,
  output vep_pkg::job_t job
);
  import vep_pkg::*;

  logic [1:0] step_r, step_nxt;
  logic busy_r, busy_nxt;
  logic signed [24:0] dx_r, dy_r, dz_r;
  logic [49:0] d2_r, d2_nxt;
  logic [15:0] rad_r, id_r;
  logic last_r;
  logic signed [24:0] cur;
  logic [49:0] sq;
  logic [16:0] upper, lower;
  logic [33:0] up2, lo2;
  logic has_low;
  cls_t cls;

  assign in_ready = !busy_r;

  // Pick the axis of the current step
  always_comb begin
    case (step_r)
      2'd0: cur = dx_r;
      2'd1: cur = dy_r;
      default: cur = dz_r;
    endcase
    sq = unsigned'(50'(cur) * 50'(cur));
  end

  assign upper = 17'(rad_r) + 17'(smooth);
  assign lower = 17'(rad_r) - 17'(smooth);
  assign has_low = rad_r > smooth;
  assign up2 = upper * upper;
  assign lo2 = lower * lower;

  assign job_valid = busy_r && step_r == 2'd3;
  assign job.d2 = d2_r;
  assign job.radius = rad_r;
  assign job.id = id_r;
  assign job.last = last_r;
  assign job.cls = cls;
  always_comb begin
    if (d2_r > 50'(up2)) cls = CLS_FAR;
    else if (has_low && d2_r < 50'(lo2)) cls = CLS_OVERLAP;
    else cls = CLS_BAND;
  end

  // Sequence the three axis squares
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    d2_nxt = d2_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt = 1'b1;
        step_nxt = 2'd0;
        d2_nxt = '0;
      end
    end else if (step_r != 2'd3) begin
      d2_nxt = d2_r + sq;
      step_nxt = step_r + 2'd1;
    end else if (job_ready) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    d2_r <= d2_nxt;
    if (!busy_r && in_valid) begin
      dx_r <= 25'(signed'(px)) - 25'(signed'(ax));
      dy_r <= 25'(signed'(py)) - 25'(signed'(ay));
      dz_r <= 25'(signed'(pz)) - 25'(signed'(az));
      rad_r <= radius;
      id_r <= id;
      last_r <= last;
    end
  end
endmodule

FILE: hw/rtl/vep_queue.sv
// Two-entry queue between front and back ends.
// Uses vep_pkg for the job type.
module vep_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  vep_pkg::job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output vep_pkg::job_t rd_data
);
  import vep_pkg::*;

  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule

FILE: hw/rtl/vep_back.sv
// Back end: square root, smoothing polynomial, running product and run state.
// Uses vep_pkg. Holds the output register.
module vep_back #(
  parameter int unsigned MAX_NEIGHBOURS = vep_pkg::MaxNeighbours
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [23:0] coef_a,
  input  logic [31:0] coef_b,
  input  logic job_valid,
  output logic job_ready,
  input  vep_pkg::job_t job,
  output logic out_valid,
  input  logic out_ready,
  output logic contributes,
  output logic [15:0] contributor_id,
  output logic overlapped,
  output logic run_done,
  output logic [23:0] exclusion_value,
  output logic [8:0] contributor_count
);
  import vep_pkg::*;

  localparam int unsigned CapRaw = (MAX_NEIGHBOURS > 511) ? 511 : MAX_NEIGHBOURS;
  localparam logic [CntW-1:0] Cap = CntW'(CapRaw);

  bk_state_t st_r, st_nxt;
  job_t job_r;
  logic [49:0] rem_r;
  logic [24:0] root_r;
  logic [4:0] it_r;
  logic signed [25:0] e_r;
  logic [31:0] e2_r;
  logic [47:0] bt_r;
  logic signed [58:0] et_r;
  logic [24:0] f_r;
  logic [23:0] prod_r;
  logic ovl_r;
  logic [CntW-1:0] cnt_r;
  logic [16:0] ae;
  logic [33:0] aesq;
  logic [63:0] bmul;
  logic signed [49:0] t;
  logic [51:0] sub;
  logic [48:0] pmul;
  logic signed [58:0] fs;
  logic signed [59:0] fsum;
  logic [23:0] new_prod;
  logic new_contrib, new_ovl;
  logic [CntW-1:0] new_cnt;
  logic ob_valid_r;
  logic ob_load;

  assign job_ready = st_r == BK_IDLE;
  assign out_valid = ob_valid_r;
  assign ob_load = st_r == BK_OUT && (!ob_valid_r || out_ready);

  // Restoring square root, one result bit per cycle
  assign sub = {2'b0, rem_r} - ({27'b0, root_r} << (it_r + 5'd1))
               - (52'd1 << (2 * it_r));

  assign ae = e_r[25] ? 17'(-e_r) : 17'(e_r);
  assign aesq = ae * ae;
  assign bmul = coef_b * e2_r;
  assign t = 50'(signed'({1'b0, coef_a})) - 50'(signed'({1'b0, bt_r}));
  assign fs = et_r >>> 5;
  assign fsum = 60'(fs) + 60'(signed'({1'b0, HalfQ23}));
  assign pmul = prod_r * f_r;

  // Next state of the sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (job_valid) st_nxt = (job.cls == CLS_BAND) ? BK_SQRT : BK_OUT;
      BK_SQRT: if (it_r == 5'd0) st_nxt = BK_E2;
      BK_E2: st_nxt = BK_BT;
      BK_BT: st_nxt = BK_ET;
      BK_ET: st_nxt = BK_PROD;
      BK_PROD: st_nxt = BK_OUT;
      BK_OUT: if (!ob_valid_r || out_ready) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Run state update for the current job
  always_comb begin
    new_prod = prod_r;
    new_ovl = ovl_r;
    new_cnt = cnt_r;
    new_contrib = 1'b0;
    if (!ovl_r) begin
      if (job_r.cls == CLS_OVERLAP) begin
        new_ovl = 1'b1;
        new_prod = '0;
        new_cnt = '0;
      end else if (job_r.cls == CLS_BAND) begin
        new_prod = 24'(pmul >> 23);
        new_contrib = 1'b1;
        if (cnt_r < Cap) new_cnt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ob_valid_r <= 1'b0;
      prod_r <= OneQ23;
      ovl_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (ob_load) begin
        ob_valid_r <= 1'b1;
        contributes <= new_contrib;
        contributor_id <= job_r.id;
        overlapped <= new_ovl;
        run_done <= job_r.last;
        exclusion_value <= new_prod;
        contributor_count <= new_cnt;
        if (job_r.last) begin
          prod_r <= OneQ23;
          ovl_r <= 1'b0;
          cnt_r <= '0;
        end else begin
          prod_r <= new_prod;
          ovl_r <= new_ovl;
          cnt_r <= new_cnt;
        end
      end else if (out_ready) begin
        ob_valid_r <= 1'b0;
      end
    end
    // Datapath registers
    unique case (st_r)
      BK_IDLE: begin
        job_r <= job;
        rem_r <= job.d2;
        root_r <= '0;
        it_r <= 5'd24;
      end
      BK_SQRT: begin
        if (!sub[51]) begin
          rem_r <= sub[49:0];
          root_r <= root_r | (25'd1 << it_r);
        end
        if (it_r != 5'd0) it_r <= it_r - 5'd1;
        else e_r <= 26'(signed'({1'b0, root_r | (sub[51] ? 25'd0 : 25'd1)}))
                    - 26'(signed'({1'b0, job_r.radius}));
      end
      BK_E2: e2_r <= 32'(aesq >> 12);
      BK_BT: bt_r <= 48'(bmul >> 12);
      BK_ET: et_r <= 59'(e_r) * 59'(t);
      BK_PROD: begin
        if (fsum < 0) f_r <= '0;
        else if (fsum > 60'(signed'({1'b0, OneQ23}))) f_r <= 25'(OneQ23);
        else f_r <= 25'(fsum);
      end
      default: ;
    endcase
  end
endmodule

FILE: dv/testbench.sv
// Self-checking testbench for volume_exclusion_product: streams neighbour atoms,
// predicts each result with an internal model and compares field by field.
// Depends on vep_pkg and the volume_exclusion_product RTL.
`timescale 1ns / 100ps

module testbench;
  import vep_pkg::*;

  typedef struct packed {
    logic [23:0] px, py, pz, ax, ay, az;
    logic [15:0] radius;
    logic [15:0] id;
    logic last;
  } atom_t;

  typedef struct packed {
    logic contrib;
    logic [15:0] id;
    logic ovl;
    logic done;
    logic [23:0] excl;
    logic [8:0] count;
  } res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [175:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [55:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CFG_SMOOTH;
  logic [31:0] cfg_data = '0;

  volume_exclusion_product DUT (.*);

  always #5 clk = ~clk;

  // Predictor state and configuration
  longint unsigned h_len = 1229, k_a = 163840, k_b = 606815;
  longint unsigned prod = 8388608, cnt = 0;
  bit ovl_seen = 0;

  atom_t pending[$];
  res_t expected_results[$];
  int errors = 0;
  bit drive_on = 0;
  int gap = 0;
  int ostall = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic res_t exclusion_step(atom_t a);
    res_t o;
    longint dx, dy, dz, e, t, f, et;
    longint unsigned d2, up, lo, ae, e2, bt;
    o = '0;
    if (!ovl_seen) begin
      dx = longint'($signed(a.px)) - longint'($signed(a.ax));
      dy = longint'($signed(a.py)) - longint'($signed(a.ay));
      dz = longint'($signed(a.pz)) - longint'($signed(a.az));
      d2 = dx * dx + dy * dy + dz * dz;
      up = a.radius + h_len;
      lo = a.radius - h_len;
      if (d2 > up * up) begin
      end else if (a.radius > h_len && d2 < lo * lo) begin
        ovl_seen = 1; prod = 0; cnt = 0;
      end else begin
        e = longint'(int_sqrt(d2)) - longint'(a.radius);
        ae = e < 0 ? -e : e;
        e2 = (ae * ae) >> 12;
        bt = (k_b * e2) >> 12;
        t = longint'(k_a) - longint'(bt);
        et = e * t;
        f = (et >>> 5) + 4194304;
        if (f < 0) f = 0;
        if (f > 8388608) f = 8388608;
        prod = (prod * f) >> 23;
        if (cnt < 256) cnt++;
        o.contrib = 1;
      end
    end
    o.id = a.id; o.ovl = ovl_seen; o.done = a.last;
    o.excl = prod[23:0]; o.count = cnt[8:0];
    if (a.last) begin
      prod = 8388608; ovl_seen = 0; cnt = 0;
    end
    return o;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Driver: present queued atoms, idle at random between transactions
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      expected_results.push_back(exclusion_step(pending.pop_front()));
    end
    if (!(in_tvalid && !in_tready)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_tvalid <= 0;
      end else if (drive_on && pending.size() > 0) begin
        in_tvalid <= 1;
        in_tdata <= {pending[0].id, pending[0].radius, pending[0].az, pending[0].ay,
                     pending[0].ax, pending[0].pz, pending[0].py, pending[0].px};
        in_tlast <= pending[0].last;
        gap <= pick_gap();
      end else in_tvalid <= 0;
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      res_t got, exp_r;
      got = {out_tdata[0], out_tdata[16:1], out_tdata[17], out_tlast,
             out_tdata[41:18], out_tdata[50:42]};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.contrib !== exp_r.contrib || got.id !== exp_r.id ||
            got.ovl !== exp_r.ovl || got.done !== exp_r.done ||
            got.excl !== exp_r.excl || got.count !== exp_r.count) begin
          $display("%0t: mismatch, expected %h actual %h", $time, exp_r, got);
          errors++;
        end
      end
    end
    // Stall the result side for random stretches, mostly short
    if (ostall > 0) begin
      ostall <= ostall - 1;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
      if ($urandom_range(0, 4) == 0) ostall <= pick_gap();
    end
  end

  function automatic logic [23:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // Atom at a chosen distance from the point along x, plus small jitter
  function automatic atom_t near_atom(logic [23:0] p, logic [15:0] r, int off, logic l);
    atom_t a;
    a.px = p; a.py = p; a.pz = p;
    a.ax = 24'(p + off); a.ay = 24'(p + $urandom_range(0, 3)); a.az = p;
    a.radius = r; a.id = 16'($urandom); a.last = l;
    return a;
  endfunction

  function automatic atom_t rnd_band_atom(logic l);
    logic [23:0] p;
    logic [15:0] r;
    int off;
    p = 24'($urandom_range(0, 24'h3fffff));
    r = 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 12000));
    off = int'(r) + int'($urandom_range(0, 32'(2 * h_len + 40))) - int'(h_len) - 20;
    if ($urandom_range(0, 1)) off = -off;
    return near_atom(p, r, off, l);
  endfunction

  task automatic drain();
    wait (pending.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_SMOOTH: h_len = v[15:0];
      CFG_COEF_A: k_a = v[23:0];
      default: k_b = v;
    endcase
  endtask

  task automatic random_runs(int n);
    int len;
    atom_t a;
    while (n > 0) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len && n > 0; i++, n--) begin
        if ($urandom_range(0, 9) < 8) a = rnd_band_atom(0);
        else begin
          a = '0;
          {a.px, a.py, a.pz} = {rnd_coord(), rnd_coord(), rnd_coord()};
          {a.ax, a.ay, a.az} = {rnd_coord(), rnd_coord(), rnd_coord()};
          a.radius = 16'($urandom); a.id = 16'($urandom);
        end
        a.last = (i == len - 1) || n == 1;
        pending.push_back(a);
      end
    end
  endtask

  initial begin
    atom_t a;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: far, overlap, edges, small radius, extremes, long run
    pending.push_back(near_atom(24'h0, 16'd4096, 9000, 0));
    pending.push_back(near_atom(24'h0, 16'd4096, 4096 + 1229, 0));
    pending.push_back(near_atom(24'h0, 16'd4096, 4096 - 1229, 0));
    pending.push_back(near_atom(24'h0, 16'd4096, 4096, 1));
    pending.push_back(near_atom(24'h100, 16'd8000, 100, 0));
    pending.push_back(near_atom(24'h100, 16'd8000, 8000, 1));
    pending.push_back(near_atom(24'h10, 16'd1000, 0, 0));
    pending.push_back(near_atom(24'h10, 16'd0, 0, 1));
    a = '0; a.px = 24'h800000; a.py = 24'h800000; a.pz = 24'h800000;
    a.ax = 24'h7fffff; a.ay = 24'h7fffff; a.az = 24'h7fffff;
    a.radius = 16'hffff; a.id = 16'hffff; a.last = 1;
    pending.push_back(a);
    a.ax = 24'h800000; a.ay = 24'h800000; a.az = 24'h800000; a.id = 16'h0;
    pending.push_back(a);
    for (int i = 0; i < 270; i++)
      pending.push_back(near_atom(24'h0, 16'd2000, 2000 + (i % 50), i == 269));
    drive_on = 1;
    drain();
    random_runs(40);
    drain();
    write_reg(CFG_SMOOTH, 32'd0);
    write_reg(CFG_COEF_A, 32'd0);
    write_reg(CFG_COEF_B, 32'd0);
    random_runs(25);
    drain();
    write_reg(CFG_SMOOTH, 32'hffff);
    write_reg(CFG_COEF_A, 32'hffffff);
    write_reg(CFG_COEF_B, 32'hffffffff);
    random_runs(25);
    drain();
    write_reg(CFG_SMOOTH, 32'd2458);
    write_reg(CFG_COEF_A, 32'd81920);
    write_reg(CFG_COEF_B, 32'd75852);
    random_runs(30);
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
